/* hw/rtl/pidc_pkg.sv */
// PID step package: fixed-point constants, control word layout, microcode ROM
// and the saturating arithmetic helpers used by the datapath.
// No dependencies.
package pidc_pkg;

	localparam int FRAC_BITS = 16;
	localparam int PROD_W    = 66;

	// Yaw wrap limits in fixed point
	localparam logic signed [33:0] HALF_TURN = 34'(180 * (1 << FRAC_BITS));
	localparam logic signed [33:0] FULL_TURN = 34'(360 * (1 << FRAC_BITS));

	// Rounding offset: half an LSB of the result
	localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (FRAC_BITS - 1);

	localparam logic signed [PROD_W-1:0] S32_MAX = PROD_W'(64'sh7FFF_FFFF);
	localparam logic signed [PROD_W-1:0] S32_MIN = -PROD_W'(64'sh8000_0000);

	typedef enum logic [2:0] {
		REG_GAIN_P,
		REG_GAIN_I,
		REG_GAIN_D,
		REG_GAIN_FF,
		REG_STEP_TIME,
		REG_STEP_RATE,
		REG_INTEG_LIMIT,
		REG_OUTPUT_LIMIT
	} cfg_reg_t;

	typedef struct packed {
		logic signed [31:0] gain_p;
		logic signed [31:0] gain_i;
		logic signed [31:0] gain_d;
		logic signed [31:0] gain_ff;
		logic [16:0]        step_time;
		logic [31:0]        step_rate;
		logic [30:0]        integ_limit;
		logic [30:0]        output_limit;
	} cfg_t;

	// Multiplier operand pair
	typedef enum logic [2:0] {
		MUL_NONE,
		MUL_ERR_DT,
		MUL_DELTA_RATE,
		MUL_P,
		MUL_I,
		MUL_D,
		MUL_FF
	} mul_sel_t;

	// Destination of the rounded product
	typedef enum logic [2:0] {
		WB_NONE,
		WB_INTEG,
		WB_DERIV,
		WB_PT,
		WB_IT,
		WB_DT,
		WB_FT
	} wb_sel_t;

	typedef logic [2:0] step_t;

	localparam step_t STEP_LAST = 3'd7;

	typedef struct packed {
		mul_sel_t mul;
		wb_sel_t  wb;
		logic     last;     // sum terms, load result, end of program
		logic     jmp_rst;  // jump to target when the item is a reset request
		step_t    target;
	} ctrl_t;

	// Microcode: issue a product in one step, write it back in the next
	function automatic ctrl_t ucode(step_t s);
		ctrl_t w;
		w = '{mul: MUL_NONE, wb: WB_NONE, last: 1'b0, jmp_rst: 1'b0, target: '0};
		unique case (s)
			3'd0: begin
				w.mul     = MUL_ERR_DT;
				w.jmp_rst = 1'b1;
				w.target  = STEP_LAST;
			end
			3'd1: begin
				w.wb  = WB_INTEG;
				w.mul = MUL_DELTA_RATE;
			end
			3'd2: begin
				w.wb  = WB_DERIV;
				w.mul = MUL_P;
			end
			3'd3: begin
				w.wb  = WB_PT;
				w.mul = MUL_I;
			end
			3'd4: begin
				w.wb  = WB_IT;
				w.mul = MUL_D;
			end
			3'd5: begin
				w.wb  = WB_DT;
				w.mul = MUL_FF;
			end
			3'd6: begin
				w.wb = WB_FT;
			end
			3'd7: begin
				w.last = 1'b1;
			end
			default: begin
				w.last = 1'b1;
			end
		endcase
		return w;
	endfunction

	function automatic logic signed [31:0] sat32(logic signed [PROD_W-1:0] x);
		logic signed [31:0] r;
		if (x > S32_MAX) begin
			r = 32'sh7FFF_FFFF;
		end else if (x < S32_MIN) begin
			r = 32'sh8000_0000;
		end else begin
			r = x[31:0];
		end
		return r;
	endfunction

	// Round to nearest, ties up, then saturate
	function automatic logic signed [31:0] fround(logic signed [PROD_W-1:0] p);
		logic signed [PROD_W-1:0] t;
		t = p + ROUND_HALF;
		return sat32(t >>> FRAC_BITS);
	endfunction

	// Reduce one turn when the difference leaves plus or minus half a turn
	function automatic logic signed [33:0] wrap_yaw(logic signed [33:0] v);
		logic signed [33:0] r;
		if (v > HALF_TURN) begin
			r = v - FULL_TURN;
		end else if (v < -HALF_TURN) begin
			r = v + FULL_TURN;
		end else begin
			r = v;
		end
		return r;
	endfunction

	// Clamp to plus or minus lim; zero lim passes the value through
	function automatic logic signed [31:0] clamp_mag(logic signed [31:0] v, logic [30:0] lim);
		logic signed [32:0] lim_s;
		logic signed [32:0] v_s;
		logic signed [31:0] r;
		lim_s = {2'b00, lim};
		v_s   = 33'(v);
		if (lim == '0) begin
			r = v;
		end else if (v_s > lim_s) begin
			r = lim_s[31:0];
		end else if (v_s < -lim_s) begin
			r = 32'(-lim_s);
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

/* hw/rtl/pid_controller_step.sv */
// PID controller step, derivative on measurement, signed Q16.16.
//
// Usage:
//   Input channel (in_valid/in_ready) carries req_type, measured, setpoint
//   and is_yaw. req_type 0 runs one control update; req_type 1 loads the
//   previous measurement, clears the integrator and reports all zeros.
//   Output channel (out_valid/out_ready) carries drive and the P, I, D and
//   feedforward terms, one transaction per input transaction, in order.
//   Configuration is a write port (cfg_we, cfg_index, cfg_data) taking
//   effect at the next edge; write it only while the block is idle.
// Sequencing:
//   An update runs the microcode steps in order; a reset request jumps from
//   the first step to the final step. The microcode program issues one product
//   per step through a single 33x33 multiplier, so updates do not overlap. A new
//   transaction is accepted in the cycle the previous result is loaded.
// Reset:
//   arst_n clears the integrator, last measurement and handshake state and
//   loads the register defaults. When the receiver stalls, the finished
//   result holds in the output register and the next item stops at its final
//   step until the output is taken.
// Depends on pidc_pkg, pidc_seq and pidc_dpath.
module pid_controller_step (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               req_type,
	input  logic signed [31:0] measured,
	input  logic signed [31:0] setpoint,
	input  logic               is_yaw,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] drive,
	output logic signed [31:0] p_term,
	output logic signed [31:0] i_term,
	output logic signed [31:0] d_term,
	output logic signed [31:0] ff_term
);

	pidc_pkg::cfg_t  cfg_q;
	pidc_pkg::ctrl_t ctrl;
	logic            busy;
	logic            out_valid_q;
	logic            stall;
	logic            load_out;
	logic            start;

	// Hold the final step while the previous result waits
	assign stall    = ctrl.last && out_valid_q && !out_ready;
	assign load_out = ctrl.last && !stall;
	assign in_ready = !busy || load_out;
	assign start    = in_valid && in_ready;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_p       <= '0;
			cfg_q.gain_i       <= '0;
			cfg_q.gain_d       <= '0;
			cfg_q.gain_ff      <= '0;
			cfg_q.step_time    <= 17'd655;
			cfg_q.step_rate    <= 32'd6553600;
			cfg_q.integ_limit  <= 31'd327680000;
			cfg_q.output_limit <= '0;
		end else if (cfg_we) begin
			unique case (pidc_pkg::cfg_reg_t'(cfg_index))
				pidc_pkg::REG_GAIN_P:       cfg_q.gain_p       <= cfg_data;
				pidc_pkg::REG_GAIN_I:       cfg_q.gain_i       <= cfg_data;
				pidc_pkg::REG_GAIN_D:       cfg_q.gain_d       <= cfg_data;
				pidc_pkg::REG_GAIN_FF:      cfg_q.gain_ff      <= cfg_data;
				pidc_pkg::REG_STEP_TIME:    cfg_q.step_time    <= cfg_data[16:0];
				pidc_pkg::REG_STEP_RATE:    cfg_q.step_rate    <= cfg_data;
				pidc_pkg::REG_INTEG_LIMIT:  cfg_q.integ_limit  <= cfg_data[30:0];
				pidc_pkg::REG_OUTPUT_LIMIT: cfg_q.output_limit <= cfg_data[30:0];
				default: begin
				end
			endcase
		end
	end

	// Output valid: set on load, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	pidc_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.start_rst (req_type),
		.stall     (stall),
		.busy      (busy),
		.ctrl      (ctrl)
	);

	pidc_dpath u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.start    (start),
		.req_type (req_type),
		.measured (measured),
		.setpoint (setpoint),
		.is_yaw   (is_yaw),
		.ctrl     (ctrl),
		.load_out (load_out),
		.drive    (drive),
		.p_term   (p_term),
		.i_term   (i_term),
		.d_term   (d_term),
		.ff_term  (ff_term)
	);

endmodule

/* hw/rtl/pidc_seq.sv */
// PID step sequencer: step counter over the microcode ROM with a conditional
// jump for reset requests. Depends on pidc_pkg.
module pidc_seq (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic            start_rst,
	input  logic            stall,
	output logic            busy,
	output pidc_pkg::ctrl_t ctrl
);

	logic            busy_q;
	logic            rst_item_q;
	pidc_pkg::step_t step_q;

	// Issue the current control word; idle issues a no-op
	always_comb begin
		ctrl = '0;
		if (busy_q) begin
			ctrl = pidc_pkg::ucode(step_q);
		end
	end

	assign busy = busy_q;

	// Advance, jump or finish
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			rst_item_q <= 1'b0;
			step_q     <= '0;
		end else if (start) begin
			busy_q     <= 1'b1;
			rst_item_q <= start_rst;
			step_q     <= '0;
		end else if (busy_q && !stall) begin
			if (ctrl.last) begin
				busy_q <= 1'b0;
			end else if (ctrl.jmp_rst && rst_item_q) begin
				step_q <= ctrl.target;
			end else begin
				step_q <= step_q + 3'd1;
			end
		end
	end

endmodule

/* hw/rtl/pidc_dpath.sv */
// PID step datapath: error and delta, one shared multiplier with rounding
// write-back, integrator state and the output sum. Depends on pidc_pkg.
module pidc_dpath (
	input  logic               clk,
	input  logic               arst_n,
	input  pidc_pkg::cfg_t     cfg,
	input  logic               start,
	input  logic               req_type,
	input  logic signed [31:0] measured,
	input  logic signed [31:0] setpoint,
	input  logic               is_yaw,
	input  pidc_pkg::ctrl_t    ctrl,
	input  logic               load_out,
	output logic signed [31:0] drive,
	output logic signed [31:0] p_term,
	output logic signed [31:0] i_term,
	output logic signed [31:0] d_term,
	output logic signed [31:0] ff_term
);

	logic signed [31:0] err_q, delta_q, setp_q, deriv_q;
	logic signed [31:0] pt_q, it_q, dt_q, ft_q;
	logic signed [31:0] acc_q, last_meas_q;
	logic               rst_item_q;
	logic signed [pidc_pkg::PROD_W-1:0] prod_q;

	logic signed [33:0] err_raw, delta_raw;
	logic signed [32:0] op_a, op_b;
	logic signed [31:0] rnd;
	logic signed [pidc_pkg::PROD_W-1:0] integ_sum, total;
	logic signed [31:0] drive_next;

	// Form error and measurement change, wrapped for yaw
	always_comb begin
		err_raw   = 34'(setpoint) - 34'(measured);
		delta_raw = 34'(last_meas_q) - 34'(measured);
		if (is_yaw) begin
			err_raw   = pidc_pkg::wrap_yaw(err_raw);
			delta_raw = pidc_pkg::wrap_yaw(delta_raw);
		end
	end

	// Select multiplier operands
	always_comb begin
		op_a = '0;
		op_b = '0;
		case (ctrl.mul)
			pidc_pkg::MUL_ERR_DT: begin
				op_a = 33'(err_q);
				op_b = {16'b0, cfg.step_time};
			end
			pidc_pkg::MUL_DELTA_RATE: begin
				op_a = 33'(delta_q);
				op_b = {1'b0, cfg.step_rate};
			end
			pidc_pkg::MUL_P: begin
				op_a = 33'(cfg.gain_p);
				op_b = 33'(err_q);
			end
			pidc_pkg::MUL_I: begin
				op_a = 33'(cfg.gain_i);
				op_b = 33'(acc_q);
			end
			pidc_pkg::MUL_D: begin
				op_a = 33'(cfg.gain_d);
				op_b = 33'(deriv_q);
			end
			pidc_pkg::MUL_FF: begin
				op_a = 33'(cfg.gain_ff);
				op_b = 33'(setp_q);
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	// Round the registered product; sum integrator and output terms
	always_comb begin
		rnd        = pidc_pkg::fround(prod_q);
		integ_sum  = pidc_pkg::PROD_W'(acc_q) + pidc_pkg::PROD_W'(rnd);
		total      = pidc_pkg::PROD_W'(pt_q) + pidc_pkg::PROD_W'(it_q)
		           + pidc_pkg::PROD_W'(dt_q) + pidc_pkg::PROD_W'(ft_q);
		drive_next = pidc_pkg::clamp_mag(pidc_pkg::sat32(total), cfg.output_limit);
	end

	// Controller state: last measurement and integrator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_meas_q <= '0;
			acc_q       <= '0;
		end else begin
			if (start) begin
				last_meas_q <= measured;
			end
			if (start && req_type) begin
				acc_q <= '0;
			end else if (ctrl.wb == pidc_pkg::WB_INTEG) begin
				acc_q <= pidc_pkg::clamp_mag(pidc_pkg::sat32(integ_sum), cfg.integ_limit);
			end
		end
	end

	// Capture the item, multiply, write back
	always_ff @(posedge clk) begin
		if (start) begin
			rst_item_q <= req_type;
			setp_q     <= setpoint;
			err_q      <= pidc_pkg::sat32(pidc_pkg::PROD_W'(err_raw));
			delta_q    <= pidc_pkg::sat32(pidc_pkg::PROD_W'(delta_raw));
		end
		if (ctrl.mul != pidc_pkg::MUL_NONE) begin
			prod_q <= pidc_pkg::PROD_W'(op_a) * pidc_pkg::PROD_W'(op_b);
		end
		case (ctrl.wb)
			pidc_pkg::WB_DERIV: deriv_q <= (cfg.step_rate == '0) ? 32'sd0 : rnd;
			pidc_pkg::WB_PT:    pt_q    <= rnd;
			pidc_pkg::WB_IT:    it_q    <= rnd;
			pidc_pkg::WB_DT:    dt_q    <= rnd;
			pidc_pkg::WB_FT:    ft_q    <= rnd;
			default: begin
			end
		endcase
	end

	// Load the result; reset requests report zeros
	always_ff @(posedge clk) begin
		if (load_out) begin
			if (rst_item_q) begin
				drive   <= '0;
				p_term  <= '0;
				i_term  <= '0;
				d_term  <= '0;
				ff_term <= '0;
			end else begin
				drive   <= drive_next;
				p_term  <= pt_q;
				i_term  <= it_q;
				d_term  <= dt_q;
				ff_term <= ft_q;
			end
		end
	end

endmodule
